[hw/rtl/bsa_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsa_pkg: shared definitions for the bitmap slab slot allocator
// Field widths, status and mode codes, default sizes and the stream layouts.
// ----------------------------------------------------------------------------
package bsa_pkg;

	// default sizes
	localparam int SIZE_CLASSES_DEF    = 8;
	localparam int SLABS_PER_CLASS_DEF = 8;
	localparam int MAX_SLOTS_DEF       = 512;
	localparam int WORD_BITS_DEF       = 64;

	// configuration registers
	localparam int CFG_REGS  = 8;
	localparam int CFG_W     = 10;
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_W-1:0] CFG_RESET = 10'd64;

	// stream field widths
	localparam int CLASS_W  = 3;
	localparam int SLAB_W   = 3;
	localparam int SLOT_W   = 9;
	localparam int STATUS_W = 2;

	// operation codes
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	// status codes
	localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_DOUBLE  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_NOFRAME = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_INVALID = 2'd3;

	// input transaction payload, lowest field last
	typedef struct packed {
		logic              pad;
		logic [SLOT_W-1:0]  slot_index;
		logic [SLAB_W-1:0]  slab_index;
		logic [CLASS_W-1:0] size_class;
	} req_t;

	// result transaction payload, lowest field last
	typedef struct packed {
		logic                slab_released;
		logic                slab_opened;
		logic [SLOT_W-1:0]   granted_slot;
		logic [SLAB_W-1:0]   granted_slab;
		logic [STATUS_W-1:0] status;
	} result_t;

endpackage
`default_nettype wire

[hw/rtl/bitmap_slab_slot_allocator.sv]
`default_nettype none
// Steps: a bad target goes from dispatch straight to the result, and a double free is found
//   after one bitmap word read; other requests search bitmap words, clear each word of an
//   opened frame, try each frame of the order list in a hint rebuild and walk order entries.
// Throughput: one request at a time; the single-port bitmap memory sets the pace. The result
//   register frees the input while a result waits.
// Reset: arst_n clears control, live masks, counts and hints; the memories need no clearing.
// ----------------------------------------------------------------------------
// bitmap_slab_slot_allocator: first-fit slab slot allocator
// Per-class slab frames with slot bitmaps held in a word memory, a creation
// order list in a second memory, and a per-class free slot hint.
// ----------------------------------------------------------------------------
module bitmap_slab_slot_allocator
	import bsa_pkg::*;
#(
	parameter int SIZE_CLASSES    = SIZE_CLASSES_DEF,
	parameter int SLABS_PER_CLASS = SLABS_PER_CLASS_DEF,
	parameter int MAX_SLOTS       = MAX_SLOTS_DEF,
	parameter int WORD_BITS       = WORD_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [15:0]          s_tdata,   // size_class, slab_index, slot_index, zero
	input  wire logic [0:0]           s_tuser,   // mode
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [15:0]               m_tdata,   // status, granted_slab, granted_slot,
	                                             // slab_opened, slab_released
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	localparam int C_W   = (SIZE_CLASSES > 1) ? $clog2(SIZE_CLASSES) : 1;
	localparam int F_W   = (SLABS_PER_CLASS > 1) ? $clog2(SLABS_PER_CLASS) : 1;
	localparam int K_W   = $clog2(SLABS_PER_CLASS + 1);
	localparam int WPS   = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
	localparam int W_W   = (WPS > 1) ? $clog2(WPS) : 1;
	localparam int B_W   = $clog2(WORD_BITS);
	localparam int ST_W  = $clog2(MAX_SLOTS + 1);
	localparam int P_W   = ST_W + 1;
	localparam int BM_D  = SIZE_CLASSES * SLABS_PER_CLASS * WPS;
	localparam int BA_W  = (BM_D > 1) ? $clog2(BM_D) : 1;
	localparam int OR_D  = SIZE_CLASSES * SLABS_PER_CLASS;
	localparam int OA_W  = (OR_D > 1) ? $clog2(OR_D) : 1;

	// sequencer states
	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_DISP = 5'd1;
	localparam logic [4:0] S_FRD  = 5'd2;
	localparam logic [4:0] S_FCHK = 5'd3;
	localparam logic [4:0] S_FRET = 5'd4;
	localparam logic [4:0] S_SET  = 5'd5;
	localparam logic [4:0] S_NEWF = 5'd6;
	localparam logic [4:0] S_OPEN = 5'd7;
	localparam logic [4:0] S_BRD  = 5'd8;
	localparam logic [4:0] S_BCHK = 5'd9;
	localparam logic [4:0] S_CLR  = 5'd10;
	localparam logic [4:0] S_LRD  = 5'd11;
	localparam logic [4:0] S_LCHK = 5'd12;
	localparam logic [4:0] S_SRD  = 5'd13;
	localparam logic [4:0] S_SWR  = 5'd14;
	localparam logic [4:0] S_REL  = 5'd15;
	localparam logic [4:0] S_RRD  = 5'd16;
	localparam logic [4:0] S_RCHK = 5'd17;
	localparam logic [4:0] S_DONE = 5'd18;

	// search continuations
	localparam logic [1:0] R_HINT  = 2'd0;
	localparam logic [1:0] R_NEXT  = 2'd1;
	localparam logic [1:0] R_EMPTY = 2'd2;
	localparam logic [1:0] R_REB   = 2'd3;

	logic [4:0]           state_q;
	logic                 mode_q;
	logic [CLASS_W-1:0]   cls_q;
	logic [SLAB_W-1:0]    fin_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [ST_W-1:0]      n_q;
	logic [F_W-1:0]       fr_q;
	logic [W_W-1:0]       w_q;
	logic [ST_W-1:0]      start_q;
	logic                 look_q;
	logic [1:0]           ret_q;
	logic                 fnd_q;
	logic [ST_W-1:0]      fslot_q;
	logic [WORD_BITS-1:0] word_q;
	logic [K_W-1:0]       k_q;
	result_t              res_q;
	result_t              res_out;
	result_t              out_q;
	logic                 m_valid_q;

	logic [CFG_W-1:0]           cfg_q   [CFG_REGS];
	logic [SLABS_PER_CLASS-1:0] live_q  [SIZE_CLASSES];
	logic [K_W-1:0]             cnt_q   [SIZE_CLASSES];
	logic                       hv_q    [SIZE_CLASSES];
	logic [F_W-1:0]             hslab_q [SIZE_CLASSES];
	logic [ST_W-1:0]            hslot_q [SIZE_CLASSES];

	// memories
	logic [WORD_BITS-1:0] bm_mem [BM_D];
	logic [WORD_BITS-1:0] bm_rd;
	logic [F_W-1:0]       ord_mem [OR_D];
	logic [F_W-1:0]       ord_rd;

	req_t                 req;
	logic [CFG_W-1:0]     cfg_sel;
	logic [ST_W-1:0]      n_acc;
	logic [C_W-1:0]       ci;
	logic [BA_W-1:0]      bm_addr;
	logic                 bm_we;
	logic [WORD_BITS-1:0] bm_wdata;
	logic [OA_W-1:0]      ord_raddr;
	logic [OA_W-1:0]      ord_waddr;
	logic                 ord_we;
	logic [F_W-1:0]       ord_wdata;
	logic [WORD_BITS-1:0] msk;
	logic [WORD_BITS-1:0] cand;
	logic [B_W-1:0]       fidx;
	logic                 found_c;
	logic [P_W-1:0]       base_c;
	logic [P_W-1:0]       next_base;
	logic [ST_W-1:0]      nxt_s;
	logic [F_W-1:0]       nf;
	logic                 nf_ok;

	assign req      = req_t'(s_tdata);
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = out_q;
	assign ci       = C_W'(cls_q);

	// usable slot count of the requested class, clamped to 1..MAX_SLOTS
	always_comb begin
		cfg_sel = cfg_q[req.size_class];
		if (cfg_sel == '0) begin
			n_acc = ST_W'(1);
		end else if (32'(cfg_sel) > MAX_SLOTS) begin
			n_acc = ST_W'(MAX_SLOTS);
		end else begin
			n_acc = ST_W'(cfg_sel);
		end
	end

	// bitmap word address and write data
	assign bm_addr = BA_W'((32'(ci) * SLABS_PER_CLASS + 32'(fr_q)) * WPS + 32'(w_q));
	always_comb begin
		bm_we    = 1'b0;
		bm_wdata = word_q;
		case (state_q)
			S_SET: begin
				bm_we    = 1'b1;
				bm_wdata = word_q | (WORD_BITS'(1) << fslot_q[B_W-1:0]);
			end
			S_OPEN: begin
				bm_we    = 1'b1;
				bm_wdata = (w_q == '0) ? WORD_BITS'(1) : '0;
			end
			S_CLR: begin
				bm_we    = 1'b1;
				bm_wdata = word_q & ~(WORD_BITS'(1) << slot_q[B_W-1:0]);
			end
			default: begin
				bm_we = 1'b0;
			end
		endcase
	end

	// order list addresses: append on open, move down on release
	always_comb begin
		ord_raddr = OA_W'(32'(ci) * SLABS_PER_CLASS + 32'(k_q));
		if (state_q == S_SRD) begin
			ord_raddr = OA_W'(32'(ci) * SLABS_PER_CLASS + 32'(k_q) + 1);
		end
		ord_we    = 1'b0;
		ord_waddr = OA_W'(32'(ci) * SLABS_PER_CLASS + 32'(k_q));
		ord_wdata = ord_rd;
		if (state_q == S_NEWF) begin
			ord_we    = nf_ok && (cnt_q[ci] < K_W'(SLABS_PER_CLASS));
			ord_waddr = OA_W'(32'(ci) * SLABS_PER_CLASS + 32'(cnt_q[ci]));
			ord_wdata = nf;
		end else if (state_q == S_SWR) begin
			ord_we = 1'b1;
		end
	end

	// word scan: window [start, n) and first candidate bit
	assign base_c    = P_W'(w_q) << B_W;
	assign next_base = (P_W'(w_q) + P_W'(1)) << B_W;
	assign nxt_s     = ST_W'(fslot_q + 1'b1);
	always_comb begin
		for (int j = 0; j < WORD_BITS; j++) begin
			msk[j] = ((base_c + P_W'(j)) >= P_W'(start_q)) &&
			         ((base_c + P_W'(j)) < P_W'(n_q));
		end
		cand    = (look_q ? bm_rd : ~bm_rd) & msk;
		found_c = |cand;
		fidx    = '0;
		for (int j = WORD_BITS - 1; j >= 0; j--) begin
			if (cand[j]) begin
				fidx = B_W'(j);
			end
		end
	end

	// lowest frame of the class that is not live
	always_comb begin
		nf    = '0;
		nf_ok = 1'b0;
		for (int j = SLABS_PER_CLASS - 1; j >= 0; j--) begin
			if (!live_q[ci][j]) begin
				nf    = F_W'(j);
				nf_ok = 1'b1;
			end
		end
	end

	// bitmap memory
	always_ff @(posedge clk) begin
		if (bm_we) begin
			bm_mem[bm_addr] <= bm_wdata;
		end
		bm_rd <= bm_mem[bm_addr];
	end

	// slab order memory
	always_ff @(posedge clk) begin
		if (ord_we) begin
			ord_mem[ord_waddr] <= ord_wdata;
		end
		ord_rd <= ord_mem[ord_raddr];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CFG_REGS; i++) begin
				cfg_q[i] <= CFG_RESET;
			end
		end else if (cfg_we) begin
			cfg_q[cfg_idx] <= cfg_data;
		end
	end

	// drop the grant fields of a failed request
	always_comb begin
		res_out = res_q;
		if (res_q.status != STAT_OK) begin
			res_out        = '0;
			res_out.status = res_q.status;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			out_q     <= '0;
		end else if (state_q == S_DONE && (!m_valid_q || m_tready)) begin
			m_valid_q <= 1'b1;
			out_q     <= res_out;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// request sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q  <= MODE_ALLOC;
			cls_q   <= '0;
			fin_q   <= '0;
			slot_q  <= '0;
			n_q     <= '0;
			fr_q    <= '0;
			w_q     <= '0;
			start_q <= '0;
			look_q  <= 1'b0;
			ret_q   <= R_HINT;
			fnd_q   <= 1'b0;
			fslot_q <= '0;
			word_q  <= '0;
			k_q     <= '0;
			res_q   <= '0;
			for (int i = 0; i < SIZE_CLASSES; i++) begin
				live_q[i]  <= '0;
				cnt_q[i]   <= '0;
				hv_q[i]    <= 1'b0;
				hslab_q[i] <= '0;
				hslot_q[i] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						mode_q  <= s_tuser[0];
						cls_q   <= req.size_class;
						fin_q   <= req.slab_index;
						slot_q  <= req.slot_index;
						n_q     <= n_acc;
						res_q   <= '0;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					if (32'(cls_q) >= SIZE_CLASSES) begin
						res_q.status <= STAT_INVALID;
						state_q      <= S_DONE;
					end else if (mode_q == MODE_ALLOC) begin
						// try the hint frame first
						if (hv_q[ci] && live_q[ci][hslab_q[ci]]) begin
							fr_q    <= hslab_q[ci];
							start_q <= hslot_q[ci];
							w_q     <= W_W'(hslot_q[ci] >> B_W);
							look_q  <= 1'b0;
							ret_q   <= R_HINT;
							state_q <= S_FRD;
						end else begin
							state_q <= S_NEWF;
						end
					end else if (32'(fin_q) >= SLABS_PER_CLASS ||
					             !live_q[ci][F_W'(fin_q)] ||
					             32'(slot_q) >= 32'(n_q)) begin
						res_q.status <= STAT_INVALID;
						state_q      <= S_DONE;
					end else begin
						fr_q    <= F_W'(fin_q);
						w_q     <= W_W'(slot_q >> B_W);
						state_q <= S_BRD;
					end
				end
				S_FRD: begin
					if (start_q >= n_q) begin
						fnd_q   <= 1'b0;
						state_q <= S_FRET;
					end else begin
						state_q <= S_FCHK;
					end
				end
				S_FCHK: begin
					word_q <= bm_rd;
					if (found_c) begin
						fnd_q   <= 1'b1;
						fslot_q <= ST_W'(base_c + P_W'(fidx));
						state_q <= S_FRET;
					end else if (next_base >= P_W'(n_q)) begin
						fnd_q   <= 1'b0;
						state_q <= S_FRET;
					end else begin
						w_q     <= w_q + 1'b1;
						state_q <= S_FRD;
					end
				end
				S_FRET: begin
					case (ret_q)
						R_HINT: begin
							if (fnd_q) begin
								res_q.granted_slab <= SLAB_W'(fr_q);
								res_q.granted_slot <= SLOT_W'(fslot_q);
								state_q            <= S_SET;
							end else begin
								state_q <= S_NEWF;
							end
						end
						R_NEXT: begin
							if (fnd_q) begin
								hv_q[ci]    <= 1'b1;
								hslab_q[ci] <= fr_q;
								hslot_q[ci] <= fslot_q;
								state_q     <= S_DONE;
							end else begin
								k_q     <= '0;
								state_q <= S_RRD;
							end
						end
						R_EMPTY: begin
							if (fnd_q) begin
								if (!hv_q[ci]) begin
									hv_q[ci]    <= 1'b1;
									hslab_q[ci] <= fr_q;
									hslot_q[ci] <= ST_W'(slot_q);
								end
								state_q <= S_DONE;
							end else begin
								k_q     <= '0;
								state_q <= S_LRD;
							end
						end
						default: begin
							if (fnd_q) begin
								hv_q[ci]    <= 1'b1;
								hslab_q[ci] <= fr_q;
								hslot_q[ci] <= fslot_q;
								state_q     <= S_DONE;
							end else begin
								k_q     <= k_q + 1'b1;
								state_q <= S_RRD;
							end
						end
					endcase
				end
				S_SET: begin
					// search onward for the next hint
					start_q <= nxt_s;
					w_q     <= W_W'(nxt_s >> B_W);
					look_q  <= 1'b0;
					ret_q   <= R_NEXT;
					state_q <= S_FRD;
				end
				S_NEWF: begin
					if (!nf_ok || cnt_q[ci] >= K_W'(SLABS_PER_CLASS)) begin
						res_q.status <= STAT_NOFRAME;
						state_q      <= S_DONE;
					end else begin
						fr_q               <= nf;
						live_q[ci][nf]     <= 1'b1;
						cnt_q[ci]          <= cnt_q[ci] + 1'b1;
						res_q.slab_opened  <= 1'b1;
						res_q.granted_slab <= SLAB_W'(nf);
						res_q.granted_slot <= '0;
						w_q                <= '0;
						state_q            <= S_OPEN;
					end
				end
				S_OPEN: begin
					// clear the frame, slot 0 taken
					if (32'(w_q) == WPS - 1) begin
						start_q <= ST_W'(1);
						w_q     <= '0;
						look_q  <= 1'b0;
						ret_q   <= R_NEXT;
						state_q <= S_FRD;
					end else begin
						w_q <= w_q + 1'b1;
					end
				end
				S_BRD: begin
					state_q <= S_BCHK;
				end
				S_BCHK: begin
					word_q <= bm_rd;
					if (!bm_rd[slot_q[B_W-1:0]]) begin
						res_q.status <= STAT_DOUBLE;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_CLR;
					end
				end
				S_CLR: begin
					// look for any reserved slot left in the frame
					start_q <= '0;
					w_q     <= '0;
					look_q  <= 1'b1;
					ret_q   <= R_EMPTY;
					state_q <= S_FRD;
				end
				S_LRD: begin
					if (k_q >= cnt_q[ci]) begin
						state_q <= S_REL;
					end else begin
						state_q <= S_LCHK;
					end
				end
				S_LCHK: begin
					if (ord_rd == fr_q) begin
						state_q <= S_SRD;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_LRD;
					end
				end
				S_SRD: begin
					if (32'(k_q) + 1 < 32'(cnt_q[ci])) begin
						state_q <= S_SWR;
					end else begin
						cnt_q[ci] <= cnt_q[ci] - 1'b1;
						state_q   <= S_REL;
					end
				end
				S_SWR: begin
					k_q     <= k_q + 1'b1;
					state_q <= S_SRD;
				end
				S_REL: begin
					live_q[ci][fr_q]    <= 1'b0;
					res_q.slab_released <= 1'b1;
					if (hv_q[ci] && hslab_q[ci] != fr_q) begin
						state_q <= S_DONE;
					end else begin
						// drop a hint on this frame and rebuild
						hv_q[ci]    <= 1'b0;
						hslab_q[ci] <= '0;
						hslot_q[ci] <= '0;
						k_q         <= '0;
						state_q     <= S_RRD;
					end
				end
				S_RRD: begin
					if (k_q >= cnt_q[ci]) begin
						hv_q[ci]    <= 1'b0;
						hslab_q[ci] <= '0;
						hslot_q[ci] <= '0;
						state_q     <= S_DONE;
					end else begin
						state_q <= S_RCHK;
					end
				end
				S_RCHK: begin
					fr_q    <= ord_rd;
					start_q <= '0;
					w_q     <= '0;
					look_q  <= 1'b0;
					ret_q   <= R_REB;
					state_q <= S_FRD;
				end
				S_DONE: begin
					if (!m_valid_q || m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_open_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_q.slab_opened |-> out_q.granted_slot == '0 &&
		out_q.status == STAT_OK && !out_q.slab_released)
		else $error("opened frame did not grant slot zero");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_q.status != STAT_OK |-> out_q.granted_slab == '0 &&
		out_q.granted_slot == '0 && !out_q.slab_opened && !out_q.slab_released)
		else $error("failed request carries grant fields");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cls_q) < SIZE_CLASSES |-> 32'(cnt_q[ci]) <= SLABS_PER_CLASS)
		else $error("slab count above frame count");

	a_hint_live: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE && 32'(cls_q) < SIZE_CLASSES && hv_q[ci] |->
		live_q[ci][hslab_q[ci]])
		else $error("valid hint on a frame that is not live");
`endif

endmodule
`default_nettype wire
